// File: rtl/frl_pkg.sv
package frl_pkg;

	localparam int SAMPLE_BITS_DEF = 24;

	localparam int POLE_W    = 32;
	localparam int POLE_FRAC = 24;
	localparam int COEF_W    = 17;
	localparam int COEF_FRAC = 16;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 14;
	localparam int FB_FRAC   = 11;

	// serial multiplier: signed a times unsigned b, one bit of b per cycle
	localparam int MUL_AW    = POLE_W + 1;
	localparam int MUL_BW    = COEF_W;
	localparam int PROD_W    = MUL_AW + MUL_BW + 1;
	localparam int MUL_CNT_W = $clog2(MUL_BW);

	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = COEF_W;

	localparam logic [COEF_W-1:0] COEF_RST  = COEF_W'(65536);
	localparam logic [GAIN_W-1:0] FBG_RST   = GAIN_W'(0);
	localparam logic [GAIN_W-1:0] ING_RST   = GAIN_W'(16384);
	localparam logic [GAIN_W-1:0] OUTG_RST  = GAIN_W'(16384);

	localparam logic signed [PROD_W-1:0] POLE_HI =
		PROD_W'((64'sd1 <<< (POLE_W - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] POLE_LO =
		PROD_W'(-(64'sd1 <<< (POLE_W - 1)));
	localparam logic signed [PROD_W-1:0] FB_ONE =
		PROD_W'(64'sd1 <<< POLE_FRAC);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CUTOFF   = 2'd0,
		REG_FEEDBACK = 2'd1,
		REG_IN_GAIN  = 2'd2,
		REG_OUT_GAIN = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_X   = 3'd0,
		OP_FB  = 3'd1,
		OP_P1  = 3'd2,
		OP_P2  = 3'd3,
		OP_P3  = 3'd4,
		OP_P4  = 3'd5,
		OP_Y   = 3'd6
	} op_t;

	function automatic logic signed [PROD_W-1:0] ext_pole(
		input logic signed [POLE_W-1:0] p);
		return {{(PROD_W-POLE_W){p[POLE_W-1]}}, p};
	endfunction

	function automatic logic signed [MUL_AW-1:0] pole_diff(
		input logic signed [POLE_W-1:0] x,
		input logic signed [POLE_W-1:0] p);
		return {x[POLE_W-1], x} - {p[POLE_W-1], p};
	endfunction

	function automatic logic signed [POLE_W-1:0] sat_pole(
		input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] r;
		priority if (v > POLE_HI) r = POLE_HI;
		else if (v < POLE_LO) r = POLE_LO;
		else r = v;
		return r[POLE_W-1:0];
	endfunction

endpackage

// File: rtl/frl_in_if.sv
interface frl_in_if #(parameter int W = frl_pkg::SAMPLE_BITS_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] in_sample;

	modport source(output valid, output in_sample, input ready);
	modport sink(input valid, input in_sample, output ready);
endinterface

// File: rtl/frl_out_if.sv
interface frl_out_if #(parameter int W = frl_pkg::SAMPLE_BITS_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_sample;

	modport source(output valid, output out_sample, input ready);
	modport sink(input valid, input out_sample, output ready);
endinterface

// File: rtl/frl_mul.sv
module frl_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [frl_pkg::MUL_AW-1:0]  a,
	input  logic        [frl_pkg::MUL_BW-1:0]  b,
	output logic                               done,
	output logic signed [frl_pkg::PROD_W-1:0]  prod
);
	import frl_pkg::*;

	logic signed [MUL_AW-1:0]  a_q;
	logic        [MUL_BW-1:0]  b_q;
	logic signed [MUL_AW:0]    hi_q;
	logic        [MUL_BW-1:0]  lo_q;
	logic        [MUL_CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic signed [MUL_AW:0] addend;
	logic signed [MUL_AW:0] sum;

	// add a when the current multiplier bit is set, then shift the partial product right
	always_comb begin
		addend = b_q[0] ? {a_q[MUL_AW-1], a_q} : '0;
		sum    = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= {sum[MUL_AW], sum[MUL_AW:1]};
			lo_q <= {sum[0], lo_q[MUL_BW-1:1]};
			b_q  <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

// File: rtl/four_pole_resonant_lowpass.sv
// channel    dir  payload                     transfer when
// audio      in   in_sample  SAMPLE_BITS s    valid && ready
// filtered   out  out_sample SAMPLE_BITS s    valid && ready
// wr_*       in   wr_index 2, wr_data 17      wr_en
//
// one sample at a time: seven products (input gain, feedback, four poles, output
// gain) run in turn through one shift-add multiplier, one step per bit of its 17-bit b
// a new sample is accepted while the previous result still waits on filtered
// arst_n clears poles to zero and loads register defaults
module four_pole_resonant_lowpass #(
	parameter int SAMPLE_BITS = frl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	frl_in_if.sink                                audio,
	frl_out_if.source                             filtered,
	input  logic                                  wr_en,
	input  logic [frl_pkg::REG_IDX_W-1:0]         wr_index,
	input  logic [frl_pkg::CFG_DATA_W-1:0]        wr_data
);
	import frl_pkg::*;

	localparam int X_SHIFT = (SAMPLE_BITS - 1) + GAIN_FRAC - POLE_FRAC;
	localparam int Y_SHIFT = POLE_FRAC + GAIN_FRAC - (SAMPLE_BITS - 1);
	localparam logic signed [PROD_W-1:0] Y_HI =
		PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] Y_LO =
		PROD_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	op_t    op_q;

	logic [COEF_W-1:0] coef_q;
	logic [GAIN_W-1:0] fbg_q;
	logic [GAIN_W-1:0] ing_q;
	logic [GAIN_W-1:0] outg_q;

	logic signed [POLE_W-1:0] stage1_q, stage2_q, stage3_q, stage4_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [POLE_W-1:0]      x_q;
	logic signed [POLE_W-1:0]      u_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          out_valid_q;

	logic                      mul_start;
	logic signed [MUL_AW-1:0]  mul_a;
	logic        [MUL_BW-1:0]  mul_b;
	logic                      mul_done;
	logic signed [PROD_W-1:0]  prod;

	logic signed [PROD_W-1:0]  sh_fb, fb_cl, sh_coef, sh_y, y_cl;
	logic signed [POLE_W-1:0]  cur_pole, new_pole, x_new, u_new;
	logic                      out_load;

	frl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	assign mul_start = (state_q == ST_ISSUE);

	always_comb begin
		unique case (op_q)
			OP_X: begin
				mul_a = {{(MUL_AW-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
				mul_b = MUL_BW'(ing_q);
			end
			OP_FB: begin
				mul_a = {stage4_q[POLE_W-1], stage4_q};
				mul_b = MUL_BW'(fbg_q);
			end
			OP_P1: begin
				mul_a = pole_diff(u_q, stage1_q);
				mul_b = coef_q;
			end
			OP_P2: begin
				mul_a = pole_diff(stage1_q, stage2_q);
				mul_b = coef_q;
			end
			OP_P3: begin
				mul_a = pole_diff(stage2_q, stage3_q);
				mul_b = coef_q;
			end
			OP_P4: begin
				mul_a = pole_diff(stage3_q, stage4_q);
				mul_b = coef_q;
			end
			default: begin
				mul_a = {stage4_q[POLE_W-1], stage4_q};
				mul_b = MUL_BW'(outg_q);
			end
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_P1:   cur_pole = stage1_q;
			OP_P2:   cur_pole = stage2_q;
			OP_P3:   cur_pole = stage3_q;
			default: cur_pole = stage4_q;
		endcase
	end

	// post-processing of the finished product, floor shifts throughout
	always_comb begin
		x_new    = sat_pole(prod >>> X_SHIFT);
		sh_fb    = prod >>> FB_FRAC;
		// feedback is limited above only
		fb_cl    = (sh_fb > FB_ONE) ? FB_ONE : sh_fb;
		u_new    = sat_pole(ext_pole(x_q) - fb_cl);
		sh_coef  = prod >>> COEF_FRAC;
		new_pole = sat_pole(ext_pole(cur_pole) + sh_coef);
		sh_y     = prod >>> Y_SHIFT;
		priority if (sh_y > Y_HI) y_cl = Y_HI;
		else if (sh_y < Y_LO) y_cl = Y_LO;
		else y_cl = sh_y;
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || filtered.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_X;
			out_valid_q <= 1'b0;
			coef_q      <= COEF_RST;
			fbg_q       <= FBG_RST;
			ing_q       <= ING_RST;
			outg_q      <= OUTG_RST;
			stage1_q    <= '0;
			stage2_q    <= '0;
			stage3_q    <= '0;
			stage4_q    <= '0;
		end else begin
			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_CUTOFF:   coef_q <= wr_data;
					REG_FEEDBACK: fbg_q  <= wr_data[GAIN_W-1:0];
					REG_IN_GAIN:  ing_q  <= wr_data[GAIN_W-1:0];
					REG_OUT_GAIN: outg_q <= wr_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (filtered.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (audio.valid) begin
						op_q    <= OP_X;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done) begin
						unique case (op_q)
							OP_P1:   stage1_q <= new_pole;
							OP_P2:   stage2_q <= new_pole;
							OP_P3:   stage3_q <= new_pole;
							OP_P4:   stage4_q <= new_pole;
							default: ;
						endcase
						if (op_q == OP_Y) begin
							state_q <= ST_DONE;
						end else begin
							op_q    <= op_t'(op_q + 3'd1);
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && audio.valid) sample_q <= audio.in_sample;
		if (state_q == ST_WAIT && mul_done) begin
			unique case (op_q)
				OP_X:    x_q <= x_new;
				OP_FB:   u_q <= u_new;
				OP_Y:    y_q <= y_cl[SAMPLE_BITS-1:0];
				default: ;
			endcase
		end
		if (out_load) out_q <= y_q;
	end

	assign audio.ready         = (state_q == ST_IDLE);
	assign filtered.valid      = out_valid_q;
	assign filtered.out_sample = out_q;

endmodule
